/* rtl/core/bffa_pkg.sv */
`default_nettype none

package bffa_pkg;

	localparam int NUM_W        = 20;
	localparam int CNT_W        = 14;
	localparam int CMP_W        = 18;
	localparam int WORD_W       = 32;
	localparam int BIT_W        = 5;
	localparam int MAP_BITS_DEF = 8192;
	localparam int REG_IDX_W    = 2;
	localparam int IN_TDATA_W   = 24;
	localparam int IN_TUSER_W   = 2;
	localparam int OUT_TDATA_W  = 24;

	typedef enum logic {
		CMD_ALLOC = 1'b0,
		CMD_FREE  = 1'b1
	} cmd_t;

	typedef enum logic {
		POOL_DATA  = 1'b0,
		POOL_INODE = 1'b1
	} pool_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_RANGE = 2'd2
	} status_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_DATA_START  = 2'd0,
		REG_DATA_COUNT  = 2'd1,
		REG_INODE_COUNT = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [NUM_W-1:0] data_start;
		logic [CNT_W-1:0] data_count;
		logic [CNT_W-1:0] inode_count;
	} cfg_t;

	typedef struct packed {
		cmd_t             command;
		pool_t            pool;
		logic [NUM_W-1:0] number;
	} req_t;

	typedef struct packed {
		logic [NUM_W-1:0] allocated;
		status_t          status;
	} res_t;

	// Position of the lowest clear bit of a map word.
	function automatic logic [BIT_W-1:0] ffz(input logic [WORD_W-1:0] w);
		logic [BIT_W-1:0] r;
		r = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (!w[i]) begin
				r = BIT_W'(i);
			end
		end
		return r;
	endfunction

endpackage

`default_nettype wire

/* rtl/core/bffa_ram.sv */
`default_nettype none

module bffa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

/* rtl/core/bffa_engine.sv */
`default_nettype none

module bffa_engine
	import bffa_pkg::*;
#(
	parameter int MAP_BITS = MAP_BITS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire cfg_t cfg,
	input  wire logic req_valid,
	input  wire req_t req,
	output logic      req_ready,
	output logic      res_valid,
	output res_t      res,
	input  wire logic res_ack
);

	localparam int NWORDS = (MAP_BITS + WORD_W - 1) / WORD_W;
	localparam int NSUM   = (NWORDS + WORD_W - 1) / WORD_W;
	localparam int MAW    = (NWORDS > 1) ? $clog2(NWORDS) : 1;
	localparam int SAW    = (NSUM > 1) ? $clog2(NSUM) : 1;
	localparam int WI_W   = SAW + BIT_W;
	localparam int IDX_W  = WI_W + BIT_W;
	localparam int MD     = 2 ** (MAW + 1);
	localparam int SD     = 2 ** (SAW + 1);

	typedef enum logic [7:0] {
		S_CLEAR = 8'b0000_0001,
		S_IDLE  = 8'b0000_0010,
		S_SCAN  = 8'b0000_0100,
		S_FCHK  = 8'b0000_1000,
		S_RD    = 8'b0001_0000,
		S_PICK  = 8'b0010_0000,
		S_UPD   = 8'b0100_0000,
		S_DONE  = 8'b1000_0000
	} state_t;

	state_t            state_q;
	req_t              req_q;
	res_t              res_q;
	logic [MAW:0]      clr_q;
	logic [SAW:0]      issue_q;
	logic              pend_q;
	logic [SAW-1:0]    chk_q;
	logic [WI_W-1:0]   word_q;
	logic [BIT_W-1:0]  bit_q;
	logic [WORD_W-1:0] mapw_q;
	logic [WORD_W-1:0] sumw_q;

	logic [MAW:0]      map_waddr, map_raddr;
	logic [SAW:0]      sum_waddr, sum_raddr;
	logic [WORD_W-1:0] map_wdata, map_rdata, sum_wdata, sum_rdata;
	logic              map_we, sum_we;

	logic [CMP_W-1:0]  usable_d, usable_i, usable_sel;
	logic              sum_found, found_ok, scan_last, issue_more;
	logic [WI_W-1:0]   found_word;
	logic [NUM_W:0]    data_hi;
	logic              free_ok;
	logic [NUM_W-1:0]  free_off;
	logic [IDX_W-1:0]  idx;
	logic              alloc_ok;
	logic [WORD_W-1:0] bit_mask, sum_mask, map_set, map_clr;

	always_comb begin
		usable_d = (CMP_W'(cfg.data_count) > CMP_W'(MAP_BITS)) ? CMP_W'(MAP_BITS)
			: CMP_W'(cfg.data_count);
		usable_i = (CMP_W'(cfg.inode_count) > CMP_W'(MAP_BITS)) ? CMP_W'(MAP_BITS)
			: CMP_W'(cfg.inode_count);
		usable_sel = (req_q.pool == POOL_DATA) ? usable_d : usable_i;

		// summary scan: a summary bit set means its map word is full
		issue_more = issue_q < (SAW + 1)'(NSUM);
		sum_found  = pend_q && !(&sum_rdata);
		found_word = {chk_q, ffz(sum_rdata)};
		found_ok   = {1'b0, found_word} < (WI_W + 1)'(NWORDS);
		scan_last  = pend_q && (chk_q == SAW'(NSUM - 1));

		// free range check
		data_hi = {1'b0, cfg.data_start} + (NUM_W + 1)'(usable_d);
		if (req_q.pool == POOL_DATA) begin
			free_ok  = (req_q.number >= cfg.data_start)
				&& ({1'b0, req_q.number} < data_hi);
			free_off = req_q.number - cfg.data_start;
		end else begin
			free_ok  = (req_q.number != '0)
				&& (req_q.number <= NUM_W'(usable_i));
			free_off = req_q.number - NUM_W'(1);
		end

		idx      = {word_q, bit_q};
		alloc_ok = CMP_W'(idx) < usable_sel;
		bit_mask = WORD_W'(1) << bit_q;
		sum_mask = WORD_W'(1) << word_q[BIT_W-1:0];
		map_set  = mapw_q | bit_mask;
		map_clr  = mapw_q & ~bit_mask;

		map_raddr = {req_q.pool, word_q[MAW-1:0]};
		sum_raddr = (state_q == S_SCAN) ? {req_q.pool, issue_q[SAW-1:0]}
			: {req_q.pool, word_q[WI_W-1:BIT_W]};

		map_we    = 1'b0;
		sum_we    = 1'b0;
		map_waddr = {req_q.pool, word_q[MAW-1:0]};
		sum_waddr = {req_q.pool, word_q[WI_W-1:BIT_W]};
		map_wdata = map_set;
		sum_wdata = sumw_q | sum_mask;
		if (state_q == S_CLEAR) begin
			map_we    = 1'b1;
			sum_we    = 1'b1;
			map_waddr = clr_q;
			sum_waddr = clr_q[SAW:0];
			map_wdata = '0;
			sum_wdata = '0;
		end else if (state_q == S_UPD) begin
			if (req_q.command == CMD_ALLOC) begin
				map_we = alloc_ok;
				sum_we = alloc_ok && (&map_set);
			end else begin
				map_we    = 1'b1;
				sum_we    = 1'b1;
				map_wdata = map_clr;
				sum_wdata = sumw_q & ~sum_mask;
			end
		end
	end

	bffa_ram #(.WIDTH(WORD_W), .DEPTH(MD)) u_map_ram (
		.clk   (clk),
		.we    (map_we),
		.waddr (map_waddr),
		.wdata (map_wdata),
		.raddr (map_raddr),
		.rdata (map_rdata)
	);

	bffa_ram #(.WIDTH(WORD_W), .DEPTH(SD)) u_sum_ram (
		.clk   (clk),
		.we    (sum_we),
		.waddr (sum_waddr),
		.wdata (sum_wdata),
		.raddr (sum_raddr),
		.rdata (sum_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			issue_q <= '0;
			pend_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (&clr_q) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_valid) begin
						issue_q <= '0;
						pend_q  <= 1'b0;
						state_q <= (req.command == CMD_ALLOC) ? S_SCAN : S_FCHK;
					end
				end
				S_SCAN: begin
					if (issue_more) begin
						issue_q <= issue_q + 1'b1;
						pend_q  <= 1'b1;
					end else begin
						pend_q <= 1'b0;
					end
					if (sum_found) begin
						state_q <= found_ok ? S_RD : S_DONE;
					end else if (scan_last) begin
						state_q <= S_DONE;
					end
				end
				S_FCHK:  state_q <= free_ok ? S_RD : S_DONE;
				S_RD:    state_q <= S_PICK;
				S_PICK:  state_q <= S_UPD;
				S_UPD:   state_q <= S_DONE;
				S_DONE: begin
					if (res_ack) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_CLEAR;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				req_q <= req;
			end
			S_SCAN: begin
				chk_q <= issue_q[SAW-1:0];
				if (sum_found && found_ok) begin
					word_q <= found_word;
				end
				res_q.allocated <= '0;
				res_q.status    <= STAT_FULL;
			end
			S_FCHK: begin
				word_q          <= free_off[IDX_W-1:BIT_W];
				bit_q           <= free_off[BIT_W-1:0];
				res_q.allocated <= '0;
				res_q.status    <= STAT_RANGE;
			end
			S_PICK: begin
				mapw_q <= map_rdata;
				sumw_q <= sum_rdata;
				if (req_q.command == CMD_ALLOC) begin
					bit_q <= ffz(map_rdata);
				end
			end
			S_UPD: begin
				res_q.allocated <= '0;
				res_q.status    <= STAT_OK;
				if (req_q.command == CMD_ALLOC) begin
					if (!alloc_ok) begin
						res_q.status <= STAT_FULL;
					end else if (req_q.pool == POOL_DATA) begin
						res_q.allocated <= cfg.data_start + NUM_W'(idx);
					end else begin
						res_q.allocated <= NUM_W'(idx) + NUM_W'(1);
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign req_ready = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);
	assign res       = res_q;

	a_sum_write_phase: assert property (@(posedge clk) disable iff (!arst_n)
		sum_we |-> (state_q == S_UPD || state_q == S_CLEAR))
		else $error("summary written outside update or clear");

	a_leave_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> (state_q == S_SCAN || state_q == S_FCHK))
		else $error("accepted request did not start work");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ack) |=> (res_valid && $stable(res_q)))
		else $error("pending result dropped or changed");

	a_free_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_UPD && req_q.command == CMD_FREE) |-> !map_wdata[bit_q])
		else $error("free did not clear its map bit");

	a_alloc_in_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_UPD && req_q.command == CMD_ALLOC && map_we)
		|-> (map_wdata != mapw_q))
		else $error("allocation picked a bit that was already set");

endmodule

`default_nettype wire

/* rtl/core/bitmap_first_fit_allocator_top.sv */
// Channel  Dir  Bus                        Contents (lowest bit first)
// s        in   s_tvalid/s_tready/s_tdata  tdata: number[19:0], pad[23:20]
//                          s_tuser         tuser: command[0], pool[1]
// m        out  m_tvalid/m_tready/m_tdata  tdata: allocated[19:0], status[21:20], pad
// cfg      in   cfg_wr_en/cfg_index/...    0 data_start, 1 data_count, 2 inode_count
//
// Free request: range check, then one map word read and write. Allocate request: a
// scan of at most NSUM = ceil(MAP_BITS / 1024) summary words; the summary memory is
// scanned one word a cycle (8 words at the default map size) before one map word read and write.
// After reset both memories are cleared, one row a cycle, over 2 * 2^ceil(log2(
// MAP_BITS / 32)) map rows (512 at the default); s_tready stays low meanwhile.
// One request is in work at a time; a finished result waits in the output register,
// and the next request is accepted while it waits.
`default_nettype none

module bitmap_first_fit_allocator_top
	import bffa_pkg::*;
#(
	parameter int MAP_BITS = MAP_BITS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // number[19:0], zero pad
	input  wire logic [IN_TUSER_W-1:0]  s_tuser,   // command, pool
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	output logic      [OUT_TDATA_W-1:0] m_tdata,   // allocated[19:0], status[21:20], pad
	input  wire logic                   cfg_wr_en,
	input  wire logic [REG_IDX_W-1:0]   cfg_index,
	input  wire logic [NUM_W-1:0]       cfg_wdata
);

	cfg_t cfg_q;
	req_t req;
	res_t res;
	res_t out_q;
	logic out_valid_q;
	logic res_valid, res_ack;

	// Configuration registers; an index past the list is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.data_start  <= '0;
			cfg_q.data_count  <= CNT_W'(8192);
			cfg_q.inode_count <= CNT_W'(8192);
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_DATA_START:  cfg_q.data_start  <= cfg_wdata;
				REG_DATA_COUNT:  cfg_q.data_count  <= cfg_wdata[CNT_W-1:0];
				REG_INODE_COUNT: cfg_q.inode_count <= cfg_wdata[CNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Unpack the request.
	always_comb begin
		req.command = cmd_t'(s_tuser[0]);
		req.pool    = pool_t'(s_tuser[1]);
		req.number  = s_tdata[NUM_W-1:0];
	end

	bffa_engine #(.MAP_BITS(MAP_BITS)) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.req_valid (s_tvalid),
		.req       (req),
		.req_ready (s_tready),
		.res_valid (res_valid),
		.res       (res),
		.res_ack   (res_ack)
	);

	// Output register: take a result when empty or being drained.
	assign res_ack = res_valid && (!out_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ack) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ack) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {(OUT_TDATA_W - NUM_W - 2)'(0), out_q.status, out_q.allocated};

endmodule

`default_nettype wire
